### src/fmtt_pkg.sv
// Package for the first-match take table: beat types, action codes and sizes.
// Used by the top level and the testbench; depends on nothing.
package fmtt_pkg;

    localparam int VALUE_W   = 31;
    localparam int POS_W     = 9;
    localparam int ACTION_W  = 2;
    localparam int DEPTH_DEF = 256;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
    } t_fmtt_in;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_fmtt_out;

    typedef struct packed {
        logic               taken;
        logic [VALUE_W-1:0] value;
    } t_fmtt_entry;

    localparam int ENTRY_W = $bits(t_fmtt_entry);

endpackage

### src/fmtt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; the width and depth come from the instantiating module.
module fmtt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/first_match_take_table.sv
// Top level of the first-match take table: sequencer, entry memory and result register.
// Depends on fmtt_pkg and fmtt_ram.
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_fmtt_in)
//   out     | output    | o_out_valid / i_out_stall| o_out_data (t_fmtt_out)
//
// Clear and append do not stall the input side.
// A query holds the input side until its result is handed over, also while an earlier
// result still waits: the entry memory has one read port and is scanned one entry per
// cycle, and the result then goes to the output register from the done state.
// The result sits in an output register, so a new beat is taken while it waits.
// Reset sets the entry count to zero; the memory needs no clearing pass, since each
// append writes its taken bit along with the value.
module first_match_take_table #(
    parameter int DEPTH = fmtt_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fmtt_pkg::t_fmtt_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fmtt_pkg::t_fmtt_out o_out_data
);
    import fmtt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         r_state,   n_state;
    logic [CW-1:0]      r_count,   n_count;
    logic [CW-1:0]      r_scan,    n_scan;
    logic               r_pend,    n_pend;
    logic [AW-1:0]      r_pend_idx, n_pend_idx;
    logic [VALUE_W-1:0] r_query,   n_query;
    t_fmtt_out          r_res,     n_res;
    logic               r_out_vld, n_out_vld;
    t_fmtt_out          r_out,     n_out;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_fmtt_entry   wr_data;
    logic          rd_en;
    t_fmtt_entry   rd_data;
    logic          in_acc;
    logic          out_free;
    logic          hit;
    logic [CW-1:0] hit_pos;

    fmtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_scan[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_vld || !i_out_stall;
    assign hit         = r_pend && !rd_data.taken && (rd_data.value == r_query);
    assign hit_pos     = CW'(r_pend_idx) + CW'(1);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_scan     = r_scan;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_query    = r_query;
        n_res      = r_res;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out      = r_out;
        wr_en      = 1'b0;
        wr_addr    = r_count[AW-1:0];
        wr_data    = '{taken: 1'b0, value: i_in_data.value};
        rd_en      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.action)
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        ACT_APPEND: begin
                            if (r_count < DEPTH_C) begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        ACT_QUERY: begin
                            n_query = i_in_data.value;
                            n_scan  = '0;
                            n_state = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pend_idx;
                    wr_data = '{taken: 1'b1, value: r_query};
                    n_res   = '{found: 1'b1, position: POS_W'(hit_pos)};
                    n_state = ST_DONE;
                end else if (r_scan < r_count) begin
                    rd_en      = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_scan[AW-1:0];
                    n_scan     = r_scan + CW'(1);
                end else begin
                    n_res   = '{found: 1'b0, position: '0};
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_pend_idx <= n_pend_idx;
        r_query    <= n_query;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count exceeds the table depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan <= r_count))
        else $error("scan index ran past the entry count");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.action == ACT_QUERY) |=> (r_state == ST_SCAN))
        else $error("accepted query did not start a scan");

    a_result_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |->
            (r_out.found ? (r_out.position != '0) : (r_out.position == '0)))
        else $error("result position does not agree with the found flag");

endmodule

### sim/first_match_take_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for first_match_take_table: queued clear, append, query and unused beats
// with random pacing, predicted results checked in order. Depends on fmtt_pkg and the RTL.
module first_match_take_table_tb;
    import fmtt_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int ITEM_TARGET   = 2000;
    localparam int MAX_GAP       = 8;
    localparam int MAX_BURST     = 24;
    localparam int MAX_STALL_RUN = 12;
    localparam int MAX_ITEMS     = 2400;
    localparam int LIMIT_CYCLES  = MAX_ITEMS * (DEPTH + 2 + MAX_GAP + MAX_STALL_RUN) * 4;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0]  VALUE_MAX  = {VALUE_W{1'b1}};

    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY} t_stall_mode;

    typedef struct packed {
        logic     drain_first;
        t_fmtt_in beat;
    } t_stim;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_fmtt_in  in_data = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_fmtt_out o_out_data;

    t_stim              pending[$];
    t_fmtt_out          due_results[$];
    logic [VALUE_W-1:0] staged_vals[$];

    logic [VALUE_W-1:0] tbl_value[DEPTH];
    logic               tbl_taken[DEPTH];
    int                 tbl_count = 0;

    int          err_count = 0;
    int          cycles = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_phase_left = 0;
    int          stall_run = 0;

    first_match_take_table #(.DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Table behavior: a query takes the lowest untaken entry that holds the value.
    function automatic void take_first_match(t_fmtt_in beat);
        t_fmtt_out res;
        case (beat.action)
            ACT_CLEAR: begin
                tbl_count = 0;
                for (int i = 0; i < DEPTH; i++) tbl_taken[i] = 1'b0;
            end
            ACT_APPEND: begin
                if (tbl_count < DEPTH) begin
                    tbl_value[tbl_count] = beat.value;
                    tbl_taken[tbl_count] = 1'b0;
                    tbl_count++;
                end
            end
            ACT_QUERY: begin
                res = '0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (!tbl_taken[i] && tbl_value[i] == beat.value) begin
                        tbl_taken[i] = 1'b1;
                        res.found = 1'b1;
                        res.position = POS_W'(i + 1);
                        break;
                    end
                end
                due_results.insert(due_results.size(), res);
            end
            default: ;
        endcase
    endfunction

    function automatic void plan_beat(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
                                      logic drain = 1'b0);
        t_stim s;
        s.drain_first = drain;
        s.beat.action = act;
        s.beat.value = val;
        pending.insert(pending.size(), s);
        if (act == ACT_CLEAR) begin
            staged_vals.delete();
        end else if (act == ACT_APPEND && staged_vals.size() < DEPTH) begin
            staged_vals.insert(staged_vals.size(), val);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(bit narrow);
        logic [31:0] r;
        r = $urandom;
        if (narrow) return VALUE_W'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0) return VALUE_MAX - VALUE_W'($urandom_range(0, 3));
        return r[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] pick_query(bit narrow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75 && staged_vals.size() != 0)
            return staged_vals[$urandom_range(0, staged_vals.size() - 1)];
        return pick_value(narrow || r < 90);
    endfunction

    // A set is usually a clear, then appends and queries mixed; full sets overfill the table.
    function automatic void plan_set(bit full, bit drain);
        int  n_app;
        int  n_qry;
        int  r;
        bit  narrow;
        bit  first;
        narrow = !full && ($urandom_range(0, 1) == 1);
        n_app = full ? DEPTH + $urandom_range(1, 4) : $urandom_range(0, 20);
        n_qry = full ? $urandom_range(20, 40) : $urandom_range(1, 24);
        first = 1'b1;
        if (full || $urandom_range(0, 4) != 0) begin
            plan_beat(ACT_CLEAR, pick_value(1'b0), drain);
            first = 1'b0;
        end
        while (n_app > 0 || n_qry > 0) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                plan_beat(ACT_UNUSED, pick_value(1'b0), drain && first);
            end else if (n_app > 0 && (full || n_qry == 0 || r < 50)) begin
                plan_beat(ACT_APPEND, pick_value(narrow), drain && first);
                n_app--;
            end else if (full && first == 1'b0 && n_qry > 0 && staged_vals.size() == DEPTH
                         && r < 8) begin
                plan_beat(ACT_QUERY, staged_vals[DEPTH - 1]);
                n_qry--;
            end else begin
                plan_beat(ACT_QUERY, pick_query(narrow), drain && first);
                n_qry--;
            end
            first = 1'b0;
        end
    endfunction

    initial begin
        int n_directed;
        int set_idx;
        int full_sets;

        // Empty table, ignored action, duplicates taken in order, then not found.
        plan_beat(ACT_QUERY, '0);
        plan_beat(ACT_UNUSED, VALUE_MAX);
        plan_beat(ACT_APPEND, VALUE_MAX);
        plan_beat(ACT_APPEND, '0);
        plan_beat(ACT_APPEND, 31'h5555_5555);
        plan_beat(ACT_APPEND, 31'h2AAA_AAAA);
        plan_beat(ACT_APPEND, VALUE_MAX);
        plan_beat(ACT_QUERY, VALUE_MAX);
        plan_beat(ACT_QUERY, VALUE_MAX);
        plan_beat(ACT_QUERY, VALUE_MAX);
        plan_beat(ACT_QUERY, '0);
        plan_beat(ACT_QUERY, 31'h5555_5555);
        plan_beat(ACT_QUERY, 31'h2AAA_AAAA);
        plan_beat(ACT_QUERY, 31'd123);
        plan_beat(ACT_UNUSED, '0);
        // Old values must not be visible after a clear.
        plan_beat(ACT_CLEAR, '0);
        plan_beat(ACT_QUERY, '0);
        plan_beat(ACT_APPEND, '0);
        plan_beat(ACT_QUERY, '0);
        n_directed = pending.size();

        set_idx = 0;
        full_sets = 0;
        while (pending.size() < n_directed + ITEM_TARGET) begin
            if (set_idx == 0 || (full_sets < 3 && $urandom_range(0, 59) == 0)) begin
                plan_set(1'b1, 1'b1);
                full_sets++;
            end else begin
                plan_set(1'b0, $urandom_range(0, 7) == 0);
            end
            set_idx++;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || in_valid || due_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    always @(posedge i_clk) begin : sender
        t_stim s;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) take_first_match(in_data);
            if (!in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending.size() == 0 ||
                             (pending[0].drain_first && due_results.size() != 0)) begin
                    in_valid <= 1'b0;
                end else begin
                    s = pending.pop_front();
                    in_data <= s.beat;
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, MAX_BURST);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : out_stall_pattern
        logic nxt;
        case (stall_mode)
            STALL_NONE: nxt = 1'b0;
            STALL_COIN: nxt = ($urandom_range(0, 1) == 1);
            default:    nxt = ($urandom_range(0, 7) != 0);
        endcase
        if (stall_run >= MAX_STALL_RUN) nxt = 1'b0;
        stall_run <= nxt ? stall_run + 1 : 0;
        out_stall <= nxt;
        if (stall_phase_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 2));
            stall_phase_left <= $urandom_range(20, 200);
        end else begin
            stall_phase_left <= stall_phase_left - 1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_fmtt_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (due_results.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual found=%0b position=%0d",
                         $time, o_out_data.found, o_out_data.position);
            end else begin
                want = due_results.pop_front();
                if (o_out_data.found !== want.found) begin
                    err_count++;
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want.found, o_out_data.found);
                end
                if (o_out_data.position !== want.position) begin
                    err_count++;
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, want.position, o_out_data.position);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
